// ===== design/mmerf_pkg.sv =====
package mmerf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 16;
  localparam int MASS_W   = 32;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] MIN_RUN_RESET = 7'd5;
  localparam logic [CFG_W-1:0] MIN_RUN_FLOOR = 7'd2;
  localparam logic [CFG_W-1:0] RUN_LEN_MAX   = 7'd127;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_item;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] run_start;
    logic [INDEX_W-1:0] run_end;
    logic [MASS_W-1:0]  run_mass;
    logic               too_long;
  } out_item_t;

  typedef struct packed {
    logic               is_last;
    logic               ovf;
    logic               qual;
    logic [MASS_W-1:0]  mass;
    logic [INDEX_W-1:0] start;
    logic [INDEX_W-1:0] stop;
  } run_cand_t;

endpackage

// ===== design/mmerf_run_track.sv =====
module mmerf_run_track
  import mmerf_pkg::*;
#(
  parameter int MAX_ITEMS  = 65536,
  parameter int VALUE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  in_item_t         item,
  input  logic [CFG_W-1:0] min_len,
  output run_cand_t        cand
);

  localparam int IDX_W = $clog2(MAX_ITEMS + 1);
  localparam int VB    = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W:0]   VLIM  = (SAMPLE_W + 1)'(1) << VB;
  localparam logic [SAMPLE_W-1:0] VMASK = SAMPLE_W'(VLIM - (SAMPLE_W + 1)'(1));

  logic [SAMPLE_W-1:0] prev_r;
  logic                have_prev_r;
  logic [CFG_W-1:0]    len_r;
  logic [INDEX_W-1:0]  start_r;
  logic [IDX_W-1:0]    idx_r;
  logic [MASS_W-1:0]   sum_r;
  logic                ovf_r;
  run_cand_t           cand_r;

  logic [SAMPLE_W-1:0] v;
  logic                full;
  logic                same;
  logic [CFG_W-1:0]    len_nxt;
  logic [CFG_W-1:0]    need;
  logic [INDEX_W-1:0]  start_nxt;
  logic [INDEX_W-1:0]  idx_low;
  logic [MASS_W:0]     sum_wide;
  logic [MASS_W-1:0]   sum_nxt;
  run_cand_t           cand_nxt;

  always_comb begin
    v         = item.sample_value & VMASK;
    full      = (idx_r == IDX_W'(MAX_ITEMS));
    same      = have_prev_r && (v == prev_r);
    idx_low   = INDEX_W'(idx_r);
    if (same) begin
      len_nxt = (len_r == RUN_LEN_MAX) ? len_r : len_r + CFG_W'(1);
    end else begin
      len_nxt = CFG_W'(1);
    end
    start_nxt = same ? start_r : idx_low;
    sum_wide  = {1'b0, sum_r} + (MASS_W + 1)'(v);
    if (same) begin
      sum_nxt = sum_wide[MASS_W] ? '1 : sum_wide[MASS_W-1:0];
    end else begin
      sum_nxt = MASS_W'(v);
    end
    need = (min_len < MIN_RUN_FLOOR) ? MIN_RUN_FLOOR : min_len;

    cand_nxt.is_last = item.last_item;
    cand_nxt.ovf     = ovf_r | full;
    cand_nxt.qual    = !full && (len_nxt >= need);
    cand_nxt.mass    = sum_nxt;
    cand_nxt.start   = start_nxt;
    cand_nxt.stop    = idx_low;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
    end else if (take) begin
      if (item.last_item) begin
        have_prev_r <= 1'b0;
        idx_r       <= '0;
        ovf_r       <= 1'b0;
      end else if (full) begin
        ovf_r <= 1'b1;
      end else begin
        have_prev_r <= 1'b1;
        idx_r       <= idx_r + IDX_W'(1);
      end
    end
  end

  // run payload, qualified by have_prev_r
  always_ff @(posedge clk) begin
    if (take) begin
      cand_r <= cand_nxt;
      if (!full) begin
        prev_r  <= v;
        len_r   <= len_nxt;
        start_r <= start_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  assign cand = cand_r;

endmodule

// ===== design/mmerf_best_keep.sv =====
module mmerf_best_keep
  import mmerf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  run_cand_t cand,
  output out_item_t result
);

  logic [MASS_W-1:0]  best_mass_r;
  logic [INDEX_W-1:0] best_start_r;
  logic [INDEX_W-1:0] best_end_r;
  logic               better;

  always_comb begin
    better = cand.qual && (cand.mass > best_mass_r);
    result.run_start = better ? cand.start : best_start_r;
    result.run_end   = better ? cand.stop  : best_end_r;
    result.run_mass  = better ? cand.mass  : best_mass_r;
    result.too_long  = cand.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_mass_r  <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
    end else if (take) begin
      if (cand.is_last) begin
        best_mass_r  <= '0;
        best_start_r <= '0;
        best_end_r   <= '0;
      end else if (better) begin
        best_mass_r  <= cand.mass;
        best_start_r <= cand.start;
        best_end_r   <= cand.stop;
      end
    end
  end

endmodule

// ===== design/max_mass_equal_run_finder.sv =====
// Heaviest equal-run finder. Samples stream in one per transfer; the item
// with last_item set closes the array and yields one result: start and end
// index and mass (value times length) of the heaviest run of equal values
// at least min_run_length long (0 and 1 act as 2), all zero if none, and
// too_long if more than MAX_ITEMS samples came in. One sample is taken
// every cycle while in_ready is high. The path is three registers deep
// (input register, run tracker, result register); a result is offered once
// the closing sample has passed through all three. in_ready falls only while a
// finished result is not yet taken and the next closing sample is in the run tracker.
module max_mass_equal_run_finder
  import mmerf_pkg::*;
#(
  parameter int MAX_ITEMS  = 65536,
  parameter int VALUE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic             in_valid_r;
  in_item_t         in_data_r;
  logic             cand_valid_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [CFG_W-1:0] min_len_r;
  logic             adv;
  run_cand_t        cand;
  out_item_t        result;

  assign adv      = !(cand_valid_r && cand.is_last && out_valid_r && !out_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_RUN_RESET;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      cand_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        in_valid_r   <= in_valid;
        cand_valid_r <= in_valid_r;
      end
      if (adv && cand_valid_r && cand.is_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_data_r <= in_data;
    end
    if (adv && cand_valid_r && cand.is_last) begin
      out_data_r <= result;
    end
  end

  mmerf_run_track #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_run (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (adv && in_valid_r),
    .item    (in_data_r),
    .min_len (min_len_r),
    .cand    (cand)
  );

  mmerf_best_keep u_best (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (adv && cand_valid_r),
    .cand   (cand),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/mmerf_checker.sv =====
module mmerf_checker
  import mmerf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // input only backs up behind an untaken result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // no recorded run means all-zero indexes
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.run_mass == '0) |->
      (out_data.run_start == '0) && (out_data.run_end == '0))
    else $error("empty result carries an index");

  // results only come out after reset has been left behind
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind max_mass_equal_run_finder mmerf_checker u_chk (.*);
